/* sv/rgbhsv_pkg.sv */
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Types and constants shared by the RGB to HSV conversion pipeline.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

	localparam int CHAN_W = 8;
	localparam int HUE_W  = 15;
	localparam int SAT_NUM_W = 16;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [HUE_W-1:0]  hue;
		logic [CHAN_W-1:0] saturation;
		logic [CHAN_W-1:0] brightness;
		logic              hue_undefined;
	} hsv_t;

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sec_t;

	// Per-pixel control that rides alongside the divider stages.
	typedef struct packed {
		sec_t              sector;
		logic              neg;
		logic              undef;
		logic [CHAN_W-1:0] brightness;
	} side_t;

endpackage

/* sv/rgb_to_hsv_converter.sv */
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Converts one 8-bit RGB pixel per beat to hue, saturation and value.
// ----------------------------------------------------------------------------
//   channel   strobe   payload   notes
//   input     start    pixel     taken when start is high and busy is low
//   output    done     result    shown for one cycle, cannot be held off
//
// A pixel is taken in every cycle; busy stays low.
// Between an accepted pixel and its result lie the front register, the
// one-bit-per-stage dividers for hue and saturation and the output register.
// Reset clears only the valid bits; data registers are not reset.
// Nothing ever stalls, so results leave in the order pixels arrived.
module rgb_to_hsv_converter import rgbhsv_pkg::*; #(
	parameter int HUE_FRAC_BITS = 6
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  rgb_t pixel,
	output logic done,
	output hsv_t result
);

	localparam int U          = 60 << HUE_FRAC_BITS;
	localparam int HQW        = $clog2(U + 1);
	localparam int DIV_STAGES = (HQW > CHAN_W) ? HQW : CHAN_W;
	localparam int HNW        = $clog2(U * 255 + 1);
	localparam int LAT        = DIV_STAGES + 2;

	logic                 vld_s1;
	side_t                side_s1;
	logic [SAT_NUM_W-1:0] sat_num_s1;
	logic [CHAN_W-1:0]    sat_den_s1, hue_den_s1;
	logic [HNW-1:0]       hue_num_s1;
	logic [DIV_STAGES-1:0] hue_quo, sat_quo;

	logic  vld_d  [DIV_STAGES];
	side_t side_d [DIV_STAGES];

	assign busy = 1'b0;

	rgbhsv_front #(.U(U), .HNW(HNW)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (start && !busy),
		.pixel     (pixel),
		.vld_s1    (vld_s1),
		.side_s1   (side_s1),
		.sat_num_s1(sat_num_s1),
		.sat_den_s1(sat_den_s1),
		.hue_num_s1(hue_num_s1),
		.hue_den_s1(hue_den_s1)
	);

	rgbhsv_div #(.QW(DIV_STAGES), .NW(HNW)) u_div_hue (
		.clk(clk),
		.num(hue_num_s1),
		.den(hue_den_s1),
		.quo(hue_quo)
	);

	rgbhsv_div #(.QW(DIV_STAGES), .NW(SAT_NUM_W)) u_div_sat (
		.clk(clk),
		.num(sat_num_s1),
		.den(sat_den_s1),
		.quo(sat_quo)
	);

	// Control for each beat follows the divider stages in lockstep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_STAGES; k++) vld_d[k] <= 1'b0;
		end else begin
			vld_d[0] <= vld_s1;
			for (int k = 1; k < DIV_STAGES; k++) vld_d[k] <= vld_d[k-1];
		end
	end

	always_ff @(posedge clk) begin
		side_d[0] <= side_s1;
		for (int k = 1; k < DIV_STAGES; k++) side_d[k] <= side_d[k-1];
	end

	rgbhsv_back #(.U(U), .QW(DIV_STAGES)) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.vld   (vld_d[DIV_STAGES-1]),
		.side  (side_d[DIV_STAGES-1]),
		.hue_q (hue_quo),
		.sat_q (sat_quo),
		.done  (done),
		.result(result)
	);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("accepted pixel did not produce a result on time");

	a_gray: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.hue_undefined |-> result.hue == '0 && result.saturation == '0)
		else $error("gray pixel with nonzero hue or saturation");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.brightness == '0 |-> result.hue_undefined)
		else $error("black pixel not flagged as undefined hue");

	a_sat_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.hue_undefined |-> result.saturation != '0)
		else $error("colored pixel with zero saturation");

endmodule

/* sv/rgbhsv_front.sv */
// ----------------------------------------------------------------------------
// rgbhsv_front
// First stage: max, min, sector choice, and dividends and divisors of both divisions.
// ----------------------------------------------------------------------------
module rgbhsv_front import rgbhsv_pkg::*; #(
	parameter int U     = 3840,
	parameter int HNW   = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_vld,
	input  rgb_t                 pixel,
	output logic                 vld_s1,
	output side_t                side_s1,
	output logic [SAT_NUM_W-1:0] sat_num_s1,
	output logic [CHAN_W-1:0]    sat_den_s1,
	output logic [HNW-1:0]       hue_num_s1,
	output logic [CHAN_W-1:0]    hue_den_s1
);

	logic [CHAN_W-1:0] mx, mn, delta, absdiff, a_ch, b_ch;
	logic [CHAN_W:0]   diff;
	sec_t              sec;

	always_comb begin
		mx = pixel.red;
		mn = pixel.red;
		if (pixel.green > mx) mx = pixel.green;
		if (pixel.blue > mx)  mx = pixel.blue;
		if (pixel.green < mn) mn = pixel.green;
		if (pixel.blue < mn)  mn = pixel.blue;
		delta = mx - mn;

		// Ties go to red first, then green.
		if (pixel.red == mx) begin
			sec  = SEC_RED;
			a_ch = pixel.green;
			b_ch = pixel.blue;
		end else if (pixel.green == mx) begin
			sec  = SEC_GREEN;
			a_ch = pixel.blue;
			b_ch = pixel.red;
		end else begin
			sec  = SEC_BLUE;
			a_ch = pixel.red;
			b_ch = pixel.green;
		end
		diff    = {1'b0, a_ch} - {1'b0, b_ch};
		absdiff = diff[CHAN_W] ? CHAN_W'(-diff) : diff[CHAN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	// A zero divisor is replaced by one with a zero dividend, so the quotient is zero.
	always_ff @(posedge clk) begin
		side_s1.sector     <= sec;
		side_s1.neg        <= diff[CHAN_W];
		side_s1.undef      <= (delta == '0);
		side_s1.brightness <= mx;
		sat_num_s1 <= (mx == '0) ? '0 :
			({delta, {CHAN_W{1'b0}}} - SAT_NUM_W'(delta));
		sat_den_s1 <= (mx == '0) ? CHAN_W'(1) : mx;
		hue_num_s1 <= (delta == '0) ? '0 : HNW'(U) * HNW'(absdiff);
		hue_den_s1 <= (delta == '0) ? CHAN_W'(1) : delta;
	end

endmodule

/* sv/rgbhsv_div.sv */
// ----------------------------------------------------------------------------
// rgbhsv_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module rgbhsv_div import rgbhsv_pkg::*; #(
	parameter int QW = 12,
	parameter int NW = 20
) (
	input  logic              clk,
	input  logic [NW-1:0]     num,
	input  logic [CHAN_W-1:0] den,
	output logic [QW-1:0]     quo
);

	localparam int CW = (NW > CHAN_W + QW) ? NW : CHAN_W + QW;

	logic [CW-1:0]     rem_s [QW];
	logic [CHAN_W-1:0] den_s [QW];
	logic [QW-1:0]     q_s   [QW];

	// The dividend is always below den * 2**QW, so the quotient fits in QW bits.
	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [CW-1:0]     rem_in, dsh;
		logic [CHAN_W-1:0] den_in;
		logic [QW-1:0]     q_in;
		logic              ge;

		if (k == 0) begin : g_first
			assign rem_in = CW'(num);
			assign den_in = den;
			assign q_in   = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign q_in   = q_s[k-1];
		end

		assign dsh = CW'(den_in) << (QW - 1 - k);
		assign ge  = (rem_in >= dsh);

		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? (rem_in - dsh) : rem_in;
			den_s[k] <= den_in;
			q_s[k]   <= {q_in[QW-2:0], ge};
		end
	end

	assign quo = q_s[QW-1];

endmodule

/* sv/rgbhsv_back.sv */
// ----------------------------------------------------------------------------
// rgbhsv_back
// Last stage: sector offset, sign, wrap of negative hue, output register.
// ----------------------------------------------------------------------------
module rgbhsv_back import rgbhsv_pkg::*; #(
	parameter int U  = 3840,
	parameter int QW = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vld,
	input  side_t         side,
	input  logic [QW-1:0] hue_q,
	input  logic [QW-1:0] sat_q,
	output logic          done,
	output hsv_t          result
);

	localparam int HSW = $clog2(6 * U + 1) + 1;

	logic signed [HSW-1:0] base, frac, hsum, hwrap;
	logic [31:0]           hue_ext;

	always_comb begin
		case (side.sector)
			SEC_RED:   base = '0;
			SEC_GREEN: base = HSW'(2 * U);
			SEC_BLUE:  base = HSW'(4 * U);
			default:   base = '0;
		endcase
		frac    = HSW'(hue_q);
		hsum    = side.neg ? (base - frac) : (base + frac);
		hwrap   = hsum[HSW-1] ? (hsum + HSW'(6 * U)) : hsum;
		hue_ext = side.undef ? '0 : 32'(unsigned'(hwrap));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld;
		end
	end

	always_ff @(posedge clk) begin
		result.hue           <= hue_ext[HUE_W-1:0];
		result.saturation    <= sat_q[CHAN_W-1:0];
		result.brightness    <= side.brightness;
		result.hue_undefined <= side.undef;
	end

endmodule

/* dv/tb_rgb_to_hsv_converter.sv */
// ----------------------------------------------------------------------------
// tb_rgb_to_hsv_converter
// Self-checking bench for the RGB to HSV converter. A short table of corner
// pixels runs first, then several hundred random pixels biased toward grays,
// tied channels, extreme channels and small spreads. Each output beat is
// checked field by field against a hand-worked result or an in-bench model.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsv_converter;
	import rgbhsv_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int HUE_FRAC   = 6;
	localparam int SECTOR_U   = 60 << HUE_FRAC;
	localparam int RAND_ITEMS = 550;
	localparam int DRAIN      = 24;
	localparam int LIMIT      = 200000;
	localparam int DIR_N      = 22;

	typedef struct packed {
		rgb_t px;
		logic typed;
		hsv_t want;
	} dir_row_t;

	// Rows with typed set carry a hand-worked result; the rest use the model.
	localparam dir_row_t DIRECTED [DIR_N] = '{
		{8'd0,   8'd0,   8'd0,   1'b1, 15'd0,     8'd0,   8'd0,   1'b1},
		{8'd255, 8'd255, 8'd255, 1'b1, 15'd0,     8'd0,   8'd255, 1'b1},
		{8'd128, 8'd128, 8'd128, 1'b1, 15'd0,     8'd0,   8'd128, 1'b1},
		{8'd1,   8'd1,   8'd1,   1'b1, 15'd0,     8'd0,   8'd1,   1'b1},
		{8'd255, 8'd0,   8'd0,   1'b1, 15'd0,     8'd255, 8'd255, 1'b0},
		{8'd0,   8'd255, 8'd0,   1'b1, 15'd7680,  8'd255, 8'd255, 1'b0},
		{8'd0,   8'd0,   8'd255, 1'b1, 15'd15360, 8'd255, 8'd255, 1'b0},
		{8'd255, 8'd255, 8'd0,   1'b1, 15'd3840,  8'd255, 8'd255, 1'b0},
		{8'd0,   8'd255, 8'd255, 1'b1, 15'd11520, 8'd255, 8'd255, 1'b0},
		{8'd255, 8'd0,   8'd255, 1'b1, 15'd19200, 8'd255, 8'd255, 1'b0},
		{8'd1,   8'd0,   8'd0,   1'b1, 15'd0,     8'd255, 8'd1,   1'b0},
		{8'd255, 8'd0,   8'd1,   1'b0, 32'd0},
		{8'd255, 8'd1,   8'd0,   1'b0, 32'd0},
		{8'd0,   8'd1,   8'd255, 1'b0, 32'd0},
		{8'd254, 8'd255, 8'd255, 1'b0, 32'd0},
		{8'd255, 8'd254, 8'd254, 1'b0, 32'd0},
		{8'd128, 8'd64,  8'd255, 1'b0, 32'd0},
		{8'd1,   8'd2,   8'd3,   1'b0, 32'd0},
		{8'd200, 8'd200, 8'd100, 1'b0, 32'd0},
		{8'd100, 8'd200, 8'd200, 1'b0, 32'd0},
		{8'd170, 8'd85,  8'd0,   1'b0, 32'd0},
		{8'd85,  8'd170, 8'd255, 1'b0, 32'd0}
	};

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	rgb_t pixel;
	logic done;
	hsv_t result;

	hsv_t        hsv_due [$];
	int          mismatches = 0;
	int unsigned cycles = 0;

	rgb_to_hsv_converter #(
		.HUE_FRAC_BITS(HUE_FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pixel(pixel),
		.done(done),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic hsv_t hsv_of_pixel(rgb_t px);
		int   r, g, b, top, bot, span, base, slope, h;
		hsv_t o;
		r = px.red;
		g = px.green;
		b = px.blue;
		top = r;
		bot = r;
		if (g > top) top = g;
		if (b > top) top = b;
		if (g < bot) bot = g;
		if (b < bot) bot = b;
		span = top - bot;
		h = 0;
		o.saturation = (top != 0) ? 8'((255 * span) / top) : 8'd0;
		o.brightness = 8'(top);
		o.hue_undefined = (span == 0);
		if (span != 0) begin
			// Ties on the maximum go to red first, then green.
			if (r == top) begin
				base = 0;
				slope = g - b;
			end else if (g == top) begin
				base = 2;
				slope = b - r;
			end else begin
				base = 4;
				slope = r - g;
			end
			h = base * SECTOR_U + (SECTOR_U * slope) / span;
			if (h < 0) h += 6 * SECTOR_U;
		end
		o.hue = h[HUE_W-1:0];
		return o;
	endfunction

	function automatic rgb_t rand_pixel();
		rgb_t p;
		int   v, lo, k;
		v = $urandom_range(0, 255);
		p = rgb_t'(24'($urandom));
		case ($urandom_range(0, 9))
			5: begin
				p = '{8'(v), 8'(v), 8'(v)};
			end
			6: begin
				k = $urandom_range(0, 2);
				if (k == 0) p = '{8'(v), 8'(v), p.blue};
				else if (k == 1) p = '{p.red, 8'(v), 8'(v)};
				else p = '{8'(v), p.green, 8'(v)};
			end
			7: begin
				p.red   = ($urandom_range(0, 1) ? 8'd255 : 8'd0) ^ 8'($urandom_range(0, 1));
				p.green = ($urandom_range(0, 1) ? 8'd255 : 8'd0) ^ 8'($urandom_range(0, 1));
				p.blue  = ($urandom_range(0, 1) ? 8'd255 : 8'd0) ^ 8'($urandom_range(0, 1));
			end
			8: begin
				// A spread of at most three codes exercises small divisors.
				lo = (v > 3) ? v - $urandom_range(0, 3) : v;
				p = '{8'($urandom_range(lo, v)), 8'($urandom_range(lo, v)),
					8'($urandom_range(lo, v))};
			end
			9: begin
				p.green = $urandom_range(0, 1) ? 8'd255 : 8'd0;
				p.blue  = $urandom_range(0, 1) ? 8'd255 : 8'd0;
			end
			default: ;
		endcase
		return p;
	endfunction

	function automatic int pick_gap(bit quiet);
		int roll;
		roll = $urandom_range(0, 99);
		if (quiet || roll < 50) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Holds start high until the beat is taken, then queues its result.
	task automatic send_pixel(rgb_t px, hsv_t want, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		pixel <= px;
		do @(posedge clk); while (busy);
		hsv_due.push_back(want);
	endtask

	task automatic cmp_field(string fld, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, fld, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : result_check
		hsv_t want;
		if (arst_n && done) begin
			if (hsv_due.size() == 0) begin
				$display("%0t: unexpected beat, expected none, got hue %0d sat %0d val %0d",
					$time, result.hue, result.saturation, result.brightness);
				mismatches++;
			end else begin
				want = hsv_due.pop_front();
				cmp_field("hue", 32'(want.hue), 32'(result.hue));
				cmp_field("saturation", 32'(want.saturation), 32'(result.saturation));
				cmp_field("brightness", 32'(want.brightness), 32'(result.brightness));
				cmp_field("hue_undefined", 32'(want.hue_undefined),
					32'(result.hue_undefined));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		rgb_t px;
		bit   quiet;
		arst_n <= 1'b0;
		start <= 1'b0;
		pixel <= '0;
		quiet = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++) begin
			px = DIRECTED[i].px;
			send_pixel(px, DIRECTED[i].typed ? DIRECTED[i].want : hsv_of_pixel(px),
				pick_gap(1'b0));
		end

		for (int i = 0; i < RAND_ITEMS; i++) begin
			// Now and then run a stretch of back-to-back beats.
			if (i % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
			px = rand_pixel();
			send_pixel(px, hsv_of_pixel(px), pick_gap(quiet));
		end
		start <= 1'b0;

		while (hsv_due.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

/* filelist.f */
sv/rgbhsv_pkg.sv
sv/rgbhsv_front.sv
sv/rgbhsv_div.sv
sv/rgbhsv_back.sv
sv/rgb_to_hsv_converter.sv
dv/tb_rgb_to_hsv_converter.sv
